[rtl/core/bba_pkg.sv]
// Shared types and codes for the buddy block allocator.
package bba_pkg;

  // largest block order, log2 of the largest pool
  localparam int ORD_LIMIT = 10;

  // order values: request orders reach 11
  localparam int ORD_W = 5;

  // datapath operation codes
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_SETUP = 4'd2;
  localparam logic [3:0] OP_ARD   = 4'd3;
  localparam logic [3:0] OP_ACHK  = 4'd4;
  localparam logic [3:0] OP_SRD   = 4'd5;
  localparam logic [3:0] OP_SWR   = 4'd6;
  localparam logic [3:0] OP_FRD   = 4'd7;
  localparam logic [3:0] OP_FCHK  = 4'd8;
  localparam logic [3:0] OP_CLR   = 4'd9;

  // status from datapath to controller
  typedef struct packed {
    logic ovr;
    logic func;
    logic bad_addr;
    logic hit;
    logic more_words;
    logic more_orders;
    logic split_more;
    logic merge;
    logic clr_last;
  } bba_sts_t;

endpackage

[rtl/core/bba_ctrl.sv]
// Controller state machine of the buddy block allocator.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       cfg_we,
  input  bba_sts_t   sts,
  output logic [3:0] op,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_ARD   = 4'd3;
  localparam logic [3:0] S_ACHK  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SWR   = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state_r, state_nxt;

  // pick next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        op = OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op        = OP_LOAD;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        op = OP_SETUP;
        if (sts.ovr) state_nxt = S_DONE;
        else if (!sts.func) state_nxt = S_ARD;
        else if (sts.bad_addr) state_nxt = S_DONE;
        else state_nxt = S_FRD;
      end
      S_ARD: begin
        op        = OP_ARD;
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        op = OP_ACHK;
        if (sts.hit) state_nxt = sts.split_more ? S_SRD : S_DONE;
        else if (sts.more_words || sts.more_orders) state_nxt = S_ARD;
        else state_nxt = S_DONE;
      end
      S_SRD: begin
        op        = OP_SRD;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        op        = OP_SWR;
        state_nxt = sts.split_more ? S_SRD : S_DONE;
      end
      S_FRD: begin
        op        = OP_FRD;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        op        = OP_FCHK;
        state_nxt = sts.merge ? S_FRD : S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
    // restart the clearing pass on a register write
    if (cfg_we) state_nxt = S_CLEAR;
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

[rtl/core/bba_dpath.sv]
// Datapath of the buddy block allocator: free map memory and work registers.
module bba_dpath
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  op,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_func,
  input  logic [10:0] in_request_size,
  input  logic [9:0]  in_block_address,
  output bba_sts_t    sts,
  output logic        out_ok,
  output logic [9:0]  out_granted_address,
  output logic [10:0] out_freed_size
);

  localparam int NW    = ORD_LIMIT + 1;
  localparam int NODES = 1 << NW;
  localparam int WB    = (NODES < 32) ? NODES : 32;
  localparam int WW    = $clog2(WB);
  localparam int AW    = (NW > WW) ? NW - WW : 1;
  localparam int DEPTH = 1 << AW;

  logic [WB-1:0]    mem [DEPTH];
  logic [WB-1:0]    rd_data_r;
  logic [ORD_W-1:0] pool_r, need_r, o_r;
  logic             func_r;
  logic [ORD_LIMIT-1:0] base_r;
  logic [NW-1:0]    node_r;
  logic [AW-1:0]    w_r, clr_r;
  logic             ok_r;
  logic [9:0]       gaddr_r;
  logic [10:0]      fsize_r;

  // lowest node of an order, and node of a block
  function automatic logic [NW-1:0] lo_of(input logic [ORD_W-1:0] o);
    lo_of = NW'(32'(1) << (ORD_LIMIT - int'(o)));
  endfunction

  function automatic logic [NW-1:0] node_of(input logic [ORD_W-1:0] o,
                                            input logic [ORD_LIMIT-1:0] a);
    node_of = NW'(32'(lo_of(o)) + (32'(a) >> o));
  endfunction

  function automatic logic [AW-1:0] word_of(input logic [NW-1:0] n);
    word_of = AW'(32'(n) >> WW);
  endfunction

  function automatic logic [WB-1:0] bit_of(input logic [NW-1:0] n);
    bit_of = WB'(1) << n[WW-1:0];
  endfunction

  // round the request size up to an order
  logic [10:0]      size_m1;
  logic [ORD_W-1:0] in_order;
  always_comb begin
    size_m1  = (in_request_size == 11'd0) ? 11'd0 : in_request_size - 11'd1;
    in_order = '0;
    for (int i = 0; i < 11; i++) begin
      if ((size_m1 >> i) != 11'd0) in_order = ORD_W'(i + 1);
    end
  end

  // saturate the written pool order
  logic [ORD_W-1:0] cfg_sat;
  assign cfg_sat = (32'(cfg_wdata) > ORD_LIMIT) ? ORD_W'(ORD_LIMIT) : ORD_W'(cfg_wdata);

  // scan window of the current order
  logic [NW-1:0]    lo_cur, cnt_cur, node_hit, split_node, root_node;
  logic [AW-1:0]    end_word;
  logic [WB-1:0]    mask, cand;
  logic [WW-1:0]    hit_idx;
  logic [ORD_W-1:0] o_up, o_dn;
  logic [ORD_LIMIT-1:0] hit_addr;
  always_comb begin
    lo_cur   = lo_of(o_r);
    cnt_cur  = NW'(32'(1) << (pool_r - o_r));
    end_word = word_of(lo_cur + cnt_cur - NW'(1));
    if (32'(cnt_cur) >= WB) mask = '1;
    else mask = WB'(((32'(1) << cnt_cur) - 32'(1)) << lo_cur[WW-1:0]);
    cand    = rd_data_r & mask;
    hit_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) hit_idx = WW'(i);
    end
    node_hit   = NW'({w_r, hit_idx});
    hit_addr   = ORD_LIMIT'(32'(node_hit - lo_cur) << o_r);
    o_up       = o_r + ORD_W'(1);
    o_dn       = o_r - ORD_W'(1);
    split_node = node_of(o_dn, ORD_LIMIT'(32'(base_r) + (32'(1) << o_dn)));
    root_node  = lo_of(pool_r);
  end

  // report status
  always_comb begin
    sts.ovr         = need_r > pool_r;
    sts.func        = func_r;
    sts.bad_addr    = ((32'(base_r) >> pool_r) != 32'd0) ||
                      ((32'(base_r) & ((32'(1) << need_r) - 32'(1))) != 32'd0);
    sts.hit         = cand != '0;
    sts.more_words  = w_r != end_word;
    sts.more_orders = o_r < pool_r;
    sts.split_more  = o_r > need_r;
    sts.merge       = (o_r < pool_r) && ((rd_data_r & bit_of(node_r ^ NW'(1))) != '0);
    sts.clr_last    = clr_r == '1;
  end

  // memory port selection
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [WB-1:0] wr_data;
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = w_r;
    wr_addr = word_of(node_r);
    wr_data = rd_data_r;
    case (op)
      OP_ARD: rd_en = 1'b1;
      OP_ACHK: begin
        wr_en   = sts.hit;
        wr_addr = w_r;
        wr_data = rd_data_r & ~bit_of(node_hit);
      end
      OP_SRD: begin
        rd_en   = 1'b1;
        rd_addr = word_of(split_node);
      end
      OP_SWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r | bit_of(node_r);
      end
      OP_FRD: begin
        rd_en   = 1'b1;
        rd_addr = word_of(node_r);
      end
      OP_FCHK: begin
        wr_en   = 1'b1;
        wr_data = sts.merge ? (rd_data_r & ~bit_of(node_r) & ~bit_of(node_r ^ NW'(1)))
                            : (rd_data_r | bit_of(node_r));
      end
      OP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == word_of(root_node)) ? bit_of(root_node) : '0;
      end
      default: ;
    endcase
  end

  // read and write the free map
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // hold configuration and clear sweep index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= (ORD_LIMIT > 10) ? ORD_W'(10) : ORD_W'(ORD_LIMIT);
      clr_r  <= '0;
    end else if (cfg_we) begin
      pool_r <= cfg_sat;
      clr_r  <= '0;
    end else if (op == OP_CLR) begin
      clr_r  <= clr_r + AW'(1);
    end
  end

  // advance work registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        func_r  <= in_func;
        need_r  <= in_order;
        base_r  <= ORD_LIMIT'(in_block_address);
        ok_r    <= 1'b0;
        gaddr_r <= '0;
        fsize_r <= '0;
      end
      OP_SETUP: begin
        o_r    <= need_r;
        w_r    <= word_of(lo_of(need_r));
        node_r <= node_of(need_r, base_r);
        if (func_r && !sts.ovr && !sts.bad_addr) begin
          ok_r    <= 1'b1;
          fsize_r <= 11'(32'(1) << need_r);
        end
      end
      OP_ACHK: begin
        if (sts.hit) begin
          node_r  <= node_hit;
          base_r  <= hit_addr;
          ok_r    <= 1'b1;
          gaddr_r <= 10'(hit_addr);
        end else if (sts.more_words) begin
          w_r <= w_r + AW'(1);
        end else if (sts.more_orders) begin
          o_r <= o_up;
          w_r <= word_of(lo_of(o_up));
        end
      end
      OP_SRD: begin
        o_r    <= o_dn;
        node_r <= split_node;
      end
      OP_FCHK: begin
        if (sts.merge) begin
          node_r <= node_r >> 1;
          o_r    <= o_up;
        end
      end
      default: ;
    endcase
  end

  assign out_ok              = ok_r;
  assign out_granted_address = gaddr_r;
  assign out_freed_size      = fsize_r;

endmodule

[rtl/core/buddy_block_allocator.sv]
// Top level of the buddy block allocator.
//
// Command channel: raise start with in_func (0 allocate, 1 free),
// in_request_size and in_block_address; the beat is taken at a rising edge
// with start high and busy low. busy stays high until the result is out.
// Result channel: out_valid is high for one cycle with out_ok,
// out_granted_address and out_freed_size; the receiver cannot stall it.
// The free map is a memory of 32-bit words, one port, read then written.
// Per command: a rejected request goes straight to the result; an allocate
// reads and checks the words of each order in turn, lowest order first, until
// a free block is found, then splits it down, each split a read and a write;
// a free reads and checks one level at a time, merging while the buddy is
// free, so it visits one level more than the merges it makes.
// One command is in flight at a time.
// Reset and every cfg_we write run a clearing pass over all words of the
// free map, busy high, leaving the whole pool free.
// cfg_wdata is the pool order, saturated to ORD_LIMIT; write it only idle.
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [10:0] in_request_size,
  input  logic [9:0]  in_block_address,
  output logic        out_valid,
  output logic        out_ok,
  output logic [9:0]  out_granted_address,
  output logic [10:0] out_freed_size,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  bba_sts_t   sts;
  logic [3:0] op;

  // sequence the command
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // hold free map and results
  bba_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .sts                 (sts),
    .out_ok              (out_ok),
    .out_granted_address (out_granted_address),
    .out_freed_size      (out_freed_size)
  );

`ifndef SYNTHESIS
  // an accepted beat keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_we) |=> busy)
    else $error("busy low after accepted beat");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a failed result carries zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_granted_address == 10'd0 && out_freed_size == 11'd0))
    else $error("failed result with nonzero fields");

  // an allocate never reports a freed size and a free never grants
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_granted_address == 10'd0 || out_freed_size == 11'd0))
    else $error("result carries both grant and freed size");
`endif

endmodule

[bench/tb_top.sv]
// Testbench for the buddy block allocator: directed table plus random traffic.
module tb_top;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORD   = ORD_LIMIT;
  localparam int NODES     = 1 << (MAX_ORD + 1);
  localparam int WDOG_MAX  = 5000;
  localparam int RAND_ITEMS = 800;
  localparam bit FN_ALLOC  = 1'b0;
  localparam bit FN_FREE   = 1'b1;

  typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    bit         ok;
    bit [9:0]   ga;
    bit [10:0]  fs;
  } alloc_res_t;

  typedef struct {
    row_kind_t  kind;
    bit         fn;
    bit [10:0]  size;
    bit [9:0]   addr;
    bit         typed;
    alloc_res_t want;
  } row_t;

  typedef struct {
    bit [9:0] addr;
    int       ord;
  } live_blk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [10:0] in_request_size = '0;
  logic [9:0]  in_block_address = '0;
  logic        out_valid;
  logic        out_ok;
  logic [9:0]  out_granted_address;
  logic [10:0] out_freed_size;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  buddy_block_allocator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  bit         free_map [NODES];
  int         pool_ord;
  alloc_res_t pending_q[$];
  live_blk_t  live_q[$];
  int         mismatches, n_alloc_ok, n_free_ok, n_reject, n_items;
  bit         no_gaps;

  function automatic int node_idx(int o, int a);
    return ((1 << (MAX_ORD - o)) + (a >> o)) & (NODES - 1);
  endfunction

  function automatic void pool_init(int v);
    pool_ord = (v > MAX_ORD) ? MAX_ORD : v;
    foreach (free_map[i]) free_map[i] = 1'b0;
    free_map[node_idx(pool_ord, 0)] = 1'b1;
    live_q.delete();
  endfunction

  function automatic int size_order(int s);
    int o;
    o = 0;
    if (s == 0) s = 1;
    while ((1 << o) < s) o++;
    return o;
  endfunction

  // compute the result of one command and update the free map
  function automatic alloc_res_t predict_block(bit fn, int s, int a);
    alloc_res_t r;
    int need, o, b, base;
    r = '{default: '0};
    need = size_order(s);
    if (need > pool_ord) return r;
    if (fn == FN_ALLOC) begin
      for (o = need; o <= pool_ord; o++) begin
        for (b = 0; b < (1 << (pool_ord - o)); b++) begin
          base = b << o;
          if (free_map[node_idx(o, base)]) begin
            free_map[node_idx(o, base)] = 1'b0;
            while (o > need) begin
              o--;
              free_map[node_idx(o, base + (1 << o))] = 1'b1;
            end
            r.ok = 1'b1;
            r.ga = 10'(base);
            live_q.push_back('{addr: 10'(base), ord: need});
            return r;
          end
        end
      end
      return r;
    end
    if ((a >> pool_ord) != 0) return r;
    if ((a & ((1 << need) - 1)) != 0) return r;
    r.ok = 1'b1;
    r.fs = 11'(1 << need);
    o = need;
    free_map[node_idx(o, a)] = 1'b1;
    // merge upward while the buddy is free
    while (o < pool_ord) begin
      b = a ^ (1 << o);
      if (!free_map[node_idx(o, b)]) break;
      free_map[node_idx(o, a)] = 1'b0;
      free_map[node_idx(o, b)] = 1'b0;
      a = a & ~(1 << o);
      o++;
      free_map[node_idx(o, a)] = 1'b1;
    end
    return r;
  endfunction

  // drive one command beat and hold it until taken
  task automatic send_cmd(bit fn, bit [10:0] s, bit [9:0] a, bit typed, alloc_res_t want);
    alloc_res_t p;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_request_size <= s;
    in_block_address <= a;
    do @(posedge clk); while (busy);
    p = predict_block(fn, s, a);
    pending_q.push_back(typed ? want : p);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool(bit [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_init(v);
  endtask

  // pick a size that rounds to order o
  function automatic bit [10:0] size_for(int o);
    int lo, hi;
    if (o == 0) return 11'($urandom_range(0, 1));
    lo = (1 << (o - 1)) + 1;
    hi = (o >= 11) ? 2047 : (1 << o);
    return 11'($urandom_range(lo, hi));
  endfunction

  task automatic random_cmd();
    int pick, k, o;
    live_blk_t lb;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // allocate, mostly small orders
      if ($urandom_range(0, 19) == 0) o = -1;
      else o = $urandom_range(0, 2) == 0 ? $urandom_range(0, pool_ord + 1)
                                          : $urandom_range(0, (pool_ord < 3) ? pool_ord : 3);
      send_cmd(FN_ALLOC, (o < 0) ? 11'($urandom) : size_for(o > 11 ? 11 : o),
               10'($urandom), 1'b0, '{default: '0});
    end else if (pick < 90 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      lb = live_q[k];
      live_q.delete(k);
      send_cmd(FN_FREE, size_for(lb.ord), lb.addr, 1'b0, '{default: '0});
    end else begin
      // noise: random free, possibly misaligned, double or out of pool
      send_cmd(FN_FREE, 11'($urandom_range(0, 2047) >> $urandom_range(0, 10)),
               10'($urandom), 1'b0, '{default: '0});
    end
  endtask

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat ok=%0d", out_ok);
      end else begin
        e = pending_q.pop_front();
        if (out_ok !== e.ok || out_granted_address !== e.ga || out_freed_size !== e.fs) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d ga=%0d fs=%0d got ok=%0d ga=%0d fs=%0d",
                     e.ok, e.ga, e.fs, out_ok, out_granted_address, out_freed_size);
        end
        if (!e.ok) n_reject++;
        else if (e.fs != 0) n_free_ok++;
        else n_alloc_ok++;
      end
    end
  end

  // abort when nothing moves for too long
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("FAIL buddy_block_allocator");
      $finish;
    end
  end

  row_t dir_tab[] = '{
    '{ROW_CMD, FN_ALLOC, 1024, 0,    1, '{1, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1,    0,    1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1024, 0,    1, '{1, 0, 1024}},
    '{ROW_CMD, FN_ALLOC, 2047, 1023, 1, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 0,    0,    1, '{1, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    1,    1, '{1, 0, 1}},
    '{ROW_CMD, FN_ALLOC, 3,    0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  2,    1,    1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1024, 512,  1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    1023, 0, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 512,  0,    0, '{0, 0, 0}},
    '{ROW_CFG, FN_ALLOC, 0,    0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1,    0,    1, '{1, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1,    0,    1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    1,    1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  2,    0,    1, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    0,    1, '{1, 0, 1}},
    '{ROW_CFG, FN_ALLOC, 15,   0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1024, 0,    1, '{1, 0, 0}},
    '{ROW_CMD, FN_FREE,  1024, 0,    1, '{1, 0, 1024}},
    '{ROW_CMD, FN_ALLOC, 1,    0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1,    0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    0,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_FREE,  1,    1,    0, '{0, 0, 0}},
    '{ROW_CMD, FN_ALLOC, 1024, 0,    0, '{0, 0, 0}}
  };

  bit [3:0] phase_pool[] = '{0, 15, 10, 3, 10, 5, 7, 10};

  initial begin
    int per_phase;
    pool_init(10);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) set_pool(dir_tab[i].size[3:0]);
      else send_cmd(dir_tab[i].fn, dir_tab[i].size, dir_tab[i].addr,
                    dir_tab[i].typed, dir_tab[i].want);
    end
    // random phases, one pool size each
    per_phase = RAND_ITEMS / phase_pool.size();
    foreach (phase_pool[p]) begin
      set_pool(phase_pool[p]);
      no_gaps = (p == phase_pool.size() - 1);
      for (int i = 0; i < per_phase; i++) begin
        if (p == 2 && i == per_phase / 2) drain();
        random_cmd();
      end
    end
    drain();
    repeat (200) @(posedge clk);
    $display("%0d commands: %0d allocations granted, %0d frees, %0d rejected",
             n_items, n_alloc_ok, n_free_ok, n_reject);
    $display("pool orders 0, 3, 5, 7, 10 and a saturating write exercised; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_q.size() == 0) $display("PASS buddy_block_allocator");
    else $display("FAIL buddy_block_allocator");
    $finish;
  end

endmodule
